// ===== hw/rtl/fpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm_pkg
// Types, character codes and character classes shared by the format pattern
// matcher and its testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpm_pkg;

    // Beat opcodes on the request channel
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_SUBJECT = 2'd1,
        OP_END     = 2'd2
    } op_t;

    // Result codes on the response channel
    typedef enum logic [2:0] {
        OC_MATCH    = 3'd0,
        OC_LITERAL  = 3'd1,
        OC_MISSING  = 3'd2,
        OC_BADSPEC  = 3'd3,
        OC_TRAILING = 3'd4
    } outcome_t;

    // Conversion phase held between subject bytes
    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_S        = 5'd1,
        PH_DI_SIGN  = 5'd2,
        PH_DI_NEED  = 5'd3,
        PH_DI_RUN   = 5'd4,
        PH_U_NEED   = 5'd5,
        PH_U_RUN    = 5'd6,
        PH_X_NEED   = 5'd7,
        PH_X_RUN    = 5'd8,
        PH_O_NEED   = 5'd9,
        PH_O_RUN    = 5'd10,
        PH_F_SIGN   = 5'd11,
        PH_F_FIRST  = 5'd12,
        PH_F_INT    = 5'd13,
        PH_F_DOT    = 5'd14,
        PH_F_FRAC   = 5'd15,
        PH_E_SIGN   = 5'd16,
        PH_E_FIRST  = 5'd17,
        PH_E_INT    = 5'd18,
        PH_E_DOT    = 5'd19,
        PH_E_FRAC   = 5'd20,
        PH_EXP_NEED = 5'd21,
        PH_EXP_RUN  = 5'd22
    } phase_t;

    // What one conversion step does with the current subject byte
    typedef enum logic [1:0] {
        CV_RETURN,
        CV_CONTINUE,
        CV_CLOSE,
        CV_MISSING
    } conv_act_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_FMT,
        ST_SPEC,
        ST_DONE
    } state_t;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_7       = 8'h37;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6C;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_SPACE, CH_TAB}) || (c inside {[CH_LF:CH_CR]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[CH_0:CH_7]};
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]}) || (c inside {[CH_A:CH_F]})
            || (c inside {[CH_UA:CH_UF]});
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fpm_in_if.sv =====
// ----------------------------------------------------------------------------
// fpm_in_if
// Request channel of the format pattern matcher: pattern loads, subject
// bytes and end-of-subject beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [5:0] pattern_index;
    logic [7:0] data_byte;

    modport source (
        output valid,
        output opcode,
        output pattern_index,
        output data_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  pattern_index,
        input  data_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/fpm_out_if.sv =====
// ----------------------------------------------------------------------------
// fpm_out_if
// Response channel of the format pattern matcher: one result beat per
// end-of-subject beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpm_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [2:0] outcome;
    logic [5:0] fail_position;

    modport source (
        output valid,
        output matched,
        output outcome,
        output fail_position,
        input  ready
    );

    modport sink (
        input  valid,
        input  matched,
        input  outcome,
        input  fail_position,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/format_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// format_pattern_matcher
// Checks a streamed subject string against a stored scanf-style format
// pattern. The pattern sits in a synchronous single-port memory of
// PATTERN_DEPTH bytes with a registered read; a small sequencer reads at
// most one pattern entry per cycle and updates position, conversion phase
// and the first failure. A pattern load is written straight from its
// request beat. A subject byte is accepted in the idle state, then the
// sequencer reads the pattern entries it needs (the element, the specifier
// after a percent sign, an l modifier) and steps an active conversion.
// End of subject takes the same walk and then posts the result, which
// waits in an output register while the next request beats are already
// taken. The memory needs no clearing after reset: the user must load an
// entry before it is read; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module format_pattern_matcher #(
    parameter int PATTERN_DEPTH = 64
) (
    input  wire       clk,
    input  wire       rst_n,
    fpm_in_if.sink    req,
    fpm_out_if.source rsp
);
    import fpm_pkg::*;

    localparam int AW = $clog2(PATTERN_DEPTH);
    localparam int PW = $clog2(PATTERN_DEPTH + 3);

    // Sequencer and matching state
    state_t    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    phase_t    phase_reg, phase_next;
    outcome_t  fcode_reg, fcode_next;
    logic [5:0] fpos_reg, fpos_next;
    logic      end_reg, end_next;
    logic      lmod_reg, lmod_next;
    logic [7:0] char_reg, char_next;

    // Pattern memory and its read port
    logic [7:0] mem [PATTERN_DEPTH];
    logic       mem_we;
    logic       rd_en;
    logic [PW-1:0] rd_pos;
    logic [7:0] mem_q;
    logic       rd_zero_reg;
    logic [7:0] fmt_byte;

    // Output register
    logic       out_valid_reg;
    logic       matched_reg;
    logic [2:0] outcome_reg;
    logic [5:0] fail_pos_reg;
    logic       out_load;
    logic       slot_free;

    // Conversion step decode
    conv_act_t  conv_act;
    phase_t     conv_phase;

    logic       in_beat;
    logic [5:0] pos6;
    logic [PW-1:0] pos_inc;
    state_t     fin_state;

    assign in_beat   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign pos6      = 6'(pos_reg);
    assign pos_inc   = pos_reg + PW'(1);
    assign fin_state = end_reg ? ST_DONE : ST_IDLE;
    assign fmt_byte  = rd_zero_reg ? CH_NUL : mem_q;

    // Write a pattern byte; loads happen only while idle, reads never then
    assign mem_we = in_beat && (req.opcode == OP_LOAD)
        && (32'(req.pattern_index) < PATTERN_DEPTH);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(req.pattern_index)] <= req.data_byte;
        end
    end

    // Read one entry; positions past the end read as the terminator
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q       <= mem[rd_pos[AW-1:0]];
            rd_zero_reg <= (rd_pos >= PW'(PATTERN_DEPTH));
        end
    end

    // Decode one step of the active conversion
    always_comb
    begin
        conv_act   = CV_CLOSE;
        conv_phase = phase_reg;
        case (phase_reg)
            PH_S:
            begin
                if (char_reg != CH_NUL && !is_space(char_reg))
                    conv_act = CV_RETURN;
            end
            PH_DI_SIGN:
            begin
                conv_phase = PH_DI_NEED;
                conv_act   = (char_reg inside {CH_PLUS, CH_MINUS}) ? CV_RETURN : CV_CONTINUE;
            end
            PH_DI_NEED:
            begin
                conv_phase = PH_DI_RUN;
                conv_act   = is_digit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_U_NEED:
            begin
                conv_phase = PH_U_RUN;
                conv_act   = is_digit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_DI_RUN, PH_U_RUN, PH_EXP_RUN:
            begin
                if (is_digit(char_reg))
                    conv_act = CV_RETURN;
            end
            PH_X_NEED:
            begin
                conv_phase = PH_X_RUN;
                conv_act   = is_xdigit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_X_RUN:
            begin
                if (is_xdigit(char_reg))
                    conv_act = CV_RETURN;
            end
            PH_O_NEED:
            begin
                conv_phase = PH_O_RUN;
                conv_act   = is_oct(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_O_RUN:
            begin
                if (is_oct(char_reg))
                    conv_act = CV_RETURN;
            end
            PH_EXP_NEED:
            begin
                conv_phase = PH_EXP_RUN;
                conv_act   = is_digit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_F_SIGN:
            begin
                conv_phase = PH_F_FIRST;
                conv_act   = (char_reg inside {CH_PLUS, CH_MINUS}) ? CV_RETURN : CV_CONTINUE;
            end
            PH_E_SIGN:
            begin
                conv_phase = PH_E_FIRST;
                conv_act   = (char_reg inside {CH_PLUS, CH_MINUS}) ? CV_RETURN : CV_CONTINUE;
            end
            PH_F_FIRST:
            begin
                conv_act = CV_RETURN;
                if (is_digit(char_reg))
                    conv_phase = PH_F_INT;
                else if (char_reg == CH_DOT)
                    conv_phase = PH_F_DOT;
                else
                    conv_act = CV_MISSING;
            end
            PH_E_FIRST:
            begin
                conv_act = CV_RETURN;
                if (is_digit(char_reg))
                    conv_phase = PH_E_INT;
                else if (char_reg == CH_DOT)
                    conv_phase = PH_E_DOT;
                else
                    conv_act = CV_MISSING;
            end
            PH_F_DOT:
            begin
                conv_phase = PH_F_FRAC;
                conv_act   = is_digit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_E_DOT:
            begin
                conv_phase = PH_E_FRAC;
                conv_act   = is_digit(char_reg) ? CV_RETURN : CV_MISSING;
            end
            PH_F_INT:
            begin
                if (is_digit(char_reg))
                    conv_act = CV_RETURN;
                else if (char_reg == CH_DOT)
                begin
                    conv_act   = CV_RETURN;
                    conv_phase = PH_F_FRAC;
                end
            end
            PH_E_INT:
            begin
                if (is_digit(char_reg))
                    conv_act = CV_RETURN;
                else if (char_reg == CH_DOT)
                begin
                    conv_act   = CV_RETURN;
                    conv_phase = PH_E_FRAC;
                end
                else if (char_reg == CH_E)
                begin
                    conv_act   = CV_RETURN;
                    conv_phase = PH_EXP_NEED;
                end
            end
            PH_F_FRAC:
            begin
                if (is_digit(char_reg))
                    conv_act = CV_RETURN;
            end
            PH_E_FRAC:
            begin
                if (is_digit(char_reg))
                    conv_act = CV_RETURN;
                else if (char_reg == CH_E)
                begin
                    conv_act   = CV_RETURN;
                    conv_phase = PH_EXP_NEED;
                end
            end
            default:
            begin
                conv_act = CV_CLOSE;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (req.opcode == OP_END)
                        state_next = ST_STEP;
                    else if (req.opcode == OP_SUBJECT && req.data_byte != CH_NUL)
                        state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (fcode_reg != OC_MATCH)
                    state_next = fin_state;
                else if (phase_reg == PH_IDLE)
                    state_next = is_blank(char_reg) ? fin_state : ST_FMT;
                else if (conv_act == CV_RETURN || conv_act == CV_MISSING)
                    state_next = fin_state;
            end
            ST_FMT:
            begin
                if (fmt_byte == CH_PERCENT)
                    state_next = ST_SPEC;
                else if (!is_blank(fmt_byte))
                    state_next = fin_state;
            end
            ST_SPEC:
            begin
                if (fmt_byte == CH_L && !lmod_reg)
                    state_next = ST_SPEC;
                else if (fmt_byte == CH_S)
                    state_next = (char_reg == CH_NUL) ? fin_state : ST_STEP;
                else if (fmt_byte inside {CH_D, CH_I, CH_U, CH_X, CH_O, CH_F, CH_E})
                    state_next = ST_STEP;
                else
                    state_next = fin_state;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and memory reads
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        fcode_next = fcode_reg;
        fpos_next  = fpos_reg;
        end_next   = end_reg;
        lmod_next  = lmod_reg;
        char_next  = char_reg;
        rd_en      = 1'b0;
        rd_pos     = pos_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // Latch the subject byte; end of subject feeds a zero
                if (in_beat)
                begin
                    end_next  = (req.opcode == OP_END);
                    char_next = (req.opcode == OP_END) ? CH_NUL : req.data_byte;
                end
            end
            ST_STEP:
            begin
                if (fcode_reg == OC_MATCH)
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        // Fetch the next pattern element
                        if (!is_blank(char_reg))
                        begin
                            rd_en     = 1'b1;
                            lmod_next = 1'b0;
                        end
                    end
                    else
                    begin
                        case (conv_act)
                            CV_RETURN, CV_CONTINUE:
                            begin
                                phase_next = conv_phase;
                            end
                            CV_MISSING:
                            begin
                                fcode_next = OC_MISSING;
                                fpos_next  = pos6;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                pos_next   = pos_inc;
                            end
                        endcase
                    end
                end
            end
            ST_FMT:
            begin
                if (fmt_byte == CH_NUL)
                begin
                    // End of pattern: leftover text fails, end of subject matches
                    fpos_next = pos6;
                    if (char_reg != CH_NUL)
                        fcode_next = OC_TRAILING;
                end
                else if (is_blank(fmt_byte) || fmt_byte == CH_PERCENT)
                begin
                    // Skip a blank entry, or fetch the specifier
                    pos_next = pos_inc;
                    rd_en    = 1'b1;
                    rd_pos   = pos_inc;
                end
                else if (fmt_byte != char_reg)
                begin
                    fcode_next = OC_LITERAL;
                    fpos_next  = pos6;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            ST_SPEC:
            begin
                if (fmt_byte == CH_L && !lmod_reg)
                begin
                    // Drop the l modifier and fetch the byte after it
                    lmod_next = 1'b1;
                    pos_next  = pos_inc;
                    rd_en     = 1'b1;
                    rd_pos    = pos_inc;
                end
                else
                begin
                    case (fmt_byte)
                        CH_PERCENT:
                        begin
                            if (char_reg != CH_PERCENT)
                            begin
                                fcode_next = OC_LITERAL;
                                fpos_next  = pos6;
                            end
                            else
                                pos_next = pos_inc;
                        end
                        CH_C:
                        begin
                            if (char_reg == CH_NUL)
                            begin
                                fcode_next = OC_MISSING;
                                fpos_next  = pos6;
                            end
                            else
                                pos_next = pos_inc;
                        end
                        CH_S:
                        begin
                            if (char_reg == CH_NUL)
                            begin
                                fcode_next = OC_MISSING;
                                fpos_next  = pos6;
                            end
                            else
                                phase_next = PH_S;
                        end
                        CH_D, CH_I:
                        begin
                            phase_next = PH_DI_SIGN;
                        end
                        CH_U:
                        begin
                            phase_next = PH_U_NEED;
                        end
                        CH_X:
                        begin
                            phase_next = PH_X_NEED;
                        end
                        CH_O:
                        begin
                            phase_next = PH_O_NEED;
                        end
                        CH_F:
                        begin
                            phase_next = PH_F_SIGN;
                        end
                        CH_E:
                        begin
                            phase_next = PH_E_SIGN;
                        end
                        default:
                        begin
                            fcode_next = OC_BADSPEC;
                            fpos_next  = pos6;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                // Post the result and rewind for the next subject
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    pos_next   = '0;
                    phase_next = PH_IDLE;
                    fcode_next = OC_MATCH;
                    fpos_next  = '0;
                    end_next   = 1'b0;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            phase_reg     <= PH_IDLE;
            fcode_reg     <= OC_MATCH;
            fpos_reg      <= '0;
            end_reg       <= 1'b0;
            lmod_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            fcode_reg <= fcode_next;
            fpos_reg  <= fpos_next;
            end_reg   <= end_next;
            lmod_reg  <= lmod_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (out_load)
        begin
            matched_reg  <= (fcode_reg == OC_MATCH);
            outcome_reg  <= fcode_reg;
            fail_pos_reg <= fpos_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.matched       = matched_reg;
    assign rsp.outcome       = outcome_reg;
    assign rsp.fail_position = fail_pos_reg;

`ifndef ASSERT_OFF
    // Pattern data is only consumed the cycle after a read was issued
    a_read_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FMT || state_reg == ST_SPEC) |-> $past(rd_en))
        else $error("pattern byte used without a read in the previous cycle");

    // Loads never overlap a walk through the pattern
    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE && !rd_en))
        else $error("pattern write outside idle");

    // A result comes only out of the posting state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result posted outside the done state");

    // Match flag and outcome agree
    a_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.matched == (rsp.outcome == OC_MATCH)))
        else $error("matched flag disagrees with outcome");

    // Position never runs past the terminator and a trailing specifier
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(PATTERN_DEPTH + 2))
        else $error("pattern position out of range");
`endif

endmodule

`default_nettype wire

// ===== test/format_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_pattern_matcher_tb
// Self-checking bench for the format pattern matcher. Loads scanf-style
// patterns, streams subject strings built to fit them (with some damaged on
// purpose, plus ignored and stray beats), and checks every end-of-subject
// result against a local behavioral predictor. Both channels idle at random;
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module format_pattern_matcher_tb;
    import fpm_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 950;
    localparam int END_TARGET  = 60;
    localparam int CALM_ITEMS  = 120;
    localparam int LONG_HOLD   = 500;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 300;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] opcode;
        logic [5:0] index;
        logic [7:0] value;
        bit         wait_drain;
    } req_beat_t;

    typedef struct {
        logic       matched;
        outcome_t   outcome;
        logic [5:0] position;
    } verdict_t;

    typedef enum {
        EL_BLANK, EL_LITERAL, EL_PERCENT, EL_CHAR, EL_STRING, EL_SIGNED,
        EL_UNSIGNED, EL_HEX, EL_OCTAL, EL_FIXED, EL_EXPO, EL_BADSPEC
    } elem_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fpm_in_if  req_ch ();
    fpm_out_if rsp_ch ();

    format_pattern_matcher #(.PATTERN_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stimulus store and expected outcomes
    req_beat_t request_q[$];
    verdict_t  verdict_q[$];
    int        beat_total;
    int        beats_done;
    int        stim_count;
    int        end_count;
    int        results_seen;
    int        errors;
    bit        drain_next;

    // Generator scratch
    logic [7:0] pat_buf[$];
    logic [7:0] subj_buf[$];
    elem_t      elems[$];

    // Predictor state
    logic [7:0] pat_mem[DEPTH];
    int         scan_pos;
    phase_t     scan_phase;
    outcome_t   fail_code;
    logic [5:0] fail_pos;

    // ------------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------------
    function automatic bit blank_ch(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    function automatic bit space_ch(input logic [7:0] c);
        return blank_ch(c) || (c >= 8'h0A && c <= 8'h0D);
    endfunction

    function automatic bit dec_ch(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit oct_ch(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h37;
    endfunction

    function automatic bit hex_ch(input logic [7:0] c);
        return dec_ch(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pattern_at(input int p);
        return p < DEPTH ? pat_mem[p] : CH_NUL;
    endfunction

    function automatic void note_failure(input outcome_t code, input int at);
        fail_code = code;
        fail_pos  = at[5:0];
    endfunction

    // Advance the match by one subject byte; zero marks the end of the subject
    function automatic void scan_subject_byte(input logic [7:0] c);
        phase_t     ph;
        int         p;
        int         q;
        logic [7:0] f;
        logic [7:0] sp;
        for (int guard = 0; guard < 4 * DEPTH + 16; guard++)
        begin
            ph = scan_phase;
            p  = scan_pos;
            if (fail_code != OC_MATCH)
                return;
            if (ph == PH_IDLE)
            begin
                if (blank_ch(c))
                    return;
                f = pattern_at(p);
                if (f == CH_NUL)
                begin
                    if (c != CH_NUL)
                        note_failure(OC_TRAILING, p);
                    else
                        fail_pos = p[5:0];
                    return;
                end
                if (blank_ch(f))
                begin
                    scan_pos = p + 1;
                    continue;
                end
                if (f != CH_PERCENT)
                begin
                    if (f != c)
                        note_failure(OC_LITERAL, p);
                    else
                        scan_pos = p + 1;
                    return;
                end
                q  = p + 1;
                sp = pattern_at(q);
                if (sp == CH_L)
                begin
                    q++;
                    sp = pattern_at(q);
                end
                case (sp)
                    CH_PERCENT:
                    begin
                        if (c != CH_PERCENT)
                            note_failure(OC_LITERAL, q);
                        else
                            scan_pos = q + 1;
                        return;
                    end
                    CH_C:
                    begin
                        if (c == CH_NUL)
                            note_failure(OC_MISSING, q);
                        else
                            scan_pos = q + 1;
                        return;
                    end
                    CH_S:
                    begin
                        if (c == CH_NUL)
                        begin
                            note_failure(OC_MISSING, q);
                            return;
                        end
                        ph = PH_S;
                    end
                    CH_D, CH_I: ph = PH_DI_SIGN;
                    CH_U:       ph = PH_U_NEED;
                    CH_X:       ph = PH_X_NEED;
                    CH_O:       ph = PH_O_NEED;
                    CH_F:       ph = PH_F_SIGN;
                    CH_E:       ph = PH_E_SIGN;
                    default:
                    begin
                        note_failure(OC_BADSPEC, q);
                        return;
                    end
                endcase
                scan_pos   = q;
                scan_phase = ph;
                continue;
            end

            // Active conversion: stay, step, fail, or fall through to close
            case (ph)
                PH_S:
                    if (c != CH_NUL && !space_ch(c))
                        return;
                PH_DI_SIGN:
                begin
                    scan_phase = PH_DI_NEED;
                    if (c == CH_PLUS || c == CH_MINUS)
                        return;
                    continue;
                end
                PH_DI_NEED, PH_U_NEED:
                begin
                    if (dec_ch(c))
                        scan_phase = phase_t'(ph + 5'd1);
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_DI_RUN, PH_U_RUN, PH_EXP_RUN:
                    if (dec_ch(c))
                        return;
                PH_X_NEED:
                begin
                    if (hex_ch(c))
                        scan_phase = PH_X_RUN;
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_X_RUN:
                    if (hex_ch(c))
                        return;
                PH_O_NEED:
                begin
                    if (oct_ch(c))
                        scan_phase = PH_O_RUN;
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_O_RUN:
                    if (oct_ch(c))
                        return;
                PH_EXP_NEED:
                begin
                    if (dec_ch(c))
                        scan_phase = PH_EXP_RUN;
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_F_SIGN, PH_E_SIGN:
                begin
                    scan_phase = (ph == PH_F_SIGN) ? PH_F_FIRST : PH_E_FIRST;
                    if (c == CH_PLUS || c == CH_MINUS)
                        return;
                    continue;
                end
                PH_F_FIRST, PH_E_FIRST:
                begin
                    if (dec_ch(c))
                        scan_phase = (ph == PH_F_FIRST) ? PH_F_INT : PH_E_INT;
                    else if (c == CH_DOT)
                        scan_phase = (ph == PH_F_FIRST) ? PH_F_DOT : PH_E_DOT;
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_F_DOT, PH_E_DOT:
                begin
                    if (dec_ch(c))
                        scan_phase = (ph == PH_F_DOT) ? PH_F_FRAC : PH_E_FRAC;
                    else
                        note_failure(OC_MISSING, p);
                    return;
                end
                PH_F_INT, PH_E_INT, PH_F_FRAC, PH_E_FRAC:
                begin
                    if (dec_ch(c))
                        return;
                    if ((ph == PH_F_INT || ph == PH_E_INT) && c == CH_DOT)
                    begin
                        scan_phase = (ph == PH_F_INT) ? PH_F_FRAC : PH_E_FRAC;
                        return;
                    end
                    if ((ph == PH_E_INT || ph == PH_E_FRAC) && c == CH_E)
                    begin
                        scan_phase = PH_EXP_NEED;
                        return;
                    end
                end
                default: ;
            endcase
            // Close the run and retry the byte on the next entry
            scan_phase = PH_IDLE;
            scan_pos   = p + 1;
        end
    endfunction

    // Apply one accepted request beat to the predictor
    function automatic void predict_beat(input req_beat_t b);
        verdict_t v;
        case (b.opcode)
            OP_LOAD:
                pat_mem[b.index] = b.value;
            OP_SUBJECT:
                if (b.value != CH_NUL)
                    scan_subject_byte(b.value);
            OP_END:
            begin
                scan_subject_byte(CH_NUL);
                v.matched  = (fail_code == OC_MATCH);
                v.outcome  = fail_code;
                v.position = fail_pos;
                verdict_q.push_back(v);
                scan_pos   = 0;
                scan_phase = PH_IDLE;
                fail_code  = OC_MATCH;
                fail_pos   = '0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    function automatic void push_beat(input logic [1:0] op, input logic [5:0] idx,
                                      input logic [7:0] val);
        req_beat_t b;
        b.opcode     = op;
        b.index      = idx;
        b.value      = val;
        b.wait_drain = drain_next;
        drain_next   = 1'b0;
        request_q.push_back(b);
        if (op == OP_LOAD || op == OP_END || (op == OP_SUBJECT && val != CH_NUL))
            stim_count++;
        if (op == OP_END)
            end_count++;
    endfunction

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic void add_run(input string set, input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
            subj_buf.push_back(pick_from(set));
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic logic [7:0] pick_literal();
        logic [7:0] v;
        if ($urandom_range(0, 3) != 0)
            return pick_from(",:;/=()#@ABZxyz019");
        v = 8'($urandom_range(1, 255));
        if (blank_ch(v) || v == CH_PERCENT)
            v = 8'hC3;
        return v;
    endfunction

    function automatic logic [7:0] spec_letter(input elem_t e);
        logic [7:0] v;
        case (e)
            EL_PERCENT:  return CH_PERCENT;
            EL_CHAR:     return CH_C;
            EL_STRING:   return CH_S;
            EL_SIGNED:   return $urandom_range(0, 1) ? CH_D : CH_I;
            EL_UNSIGNED: return CH_U;
            EL_HEX:      return CH_X;
            EL_OCTAL:    return CH_O;
            EL_FIXED:    return CH_F;
            EL_EXPO:     return CH_E;
            default:
            begin
                v = 8'($urandom_range(1, 255));
                if (v inside {CH_PERCENT, CH_C, CH_S, CH_D, CH_I, CH_U, CH_X, CH_O,
                              CH_F, CH_E, CH_L})
                    v = 8'h71;
                return v;
            end
        endcase
    endfunction

    // Draw a random pattern into pat_buf and remember its elements
    function automatic void make_pattern();
        elem_t e;
        int    r;
        elems.delete();
        pat_buf.delete();
        repeat ($urandom_range(1, 8))
        begin
            if (pat_buf.size() > 56)
                break;
            e = elem_t'($urandom_range(0, EL_BADSPEC));
            if (e == EL_BADSPEC && $urandom_range(0, 5) != 0)
                e = EL_LITERAL;
            case (e)
                EL_BLANK:   pat_buf.push_back(pick_blank());
                EL_LITERAL: pat_buf.push_back(pick_literal());
                default:
                begin
                    pat_buf.push_back(CH_PERCENT);
                    if ($urandom_range(0, 3) == 0)
                        pat_buf.push_back(CH_L);
                    pat_buf.push_back(spec_letter(e));
                end
            endcase
            elems.push_back(e);
        end
        // Occasionally end on a dangling percent or run off the store
        r = $urandom_range(0, 19);
        if (r == 0)
            pat_buf.push_back(CH_PERCENT);
        else if (r == 1)
        begin
            pat_buf.push_back(CH_PERCENT);
            pat_buf.push_back(CH_L);
        end
        else if (r == 2)
            while (pat_buf.size() < DEPTH)
                pat_buf.push_back(CH_SPACE);
    endfunction

    function automatic void load_pattern();
        foreach (pat_buf[i])
            push_beat(OP_LOAD, 6'(i), pat_buf[i]);
        if (pat_buf.size() < DEPTH)
            push_beat(OP_LOAD, 6'(pat_buf.size()), CH_NUL);
    endfunction

    function automatic void pattern_text(input string s);
        pat_buf.delete();
        for (int i = 0; i < s.len(); i++)
            pat_buf.push_back(s[i]);
        load_pattern();
    endfunction

    // Find the pattern byte of literal element k by walking pat_buf
    function automatic logic [7:0] literal_of(input int k);
        int at;
        at = 0;
        for (int i = 0; i < k; i++)
        begin
            if (elems[i] == EL_BLANK || elems[i] == EL_LITERAL)
                at++;
            else
                at += (pat_buf[at + 1] == CH_L) ? 3 : 2;
        end
        return pat_buf[at];
    endfunction

    // Build a subject that fits the remembered elements
    function automatic void make_subject();
        bit greedy;
        int lit_at;
        subj_buf.delete();
        lit_at = 0;
        foreach (elems[k])
        begin
            greedy = 1'b1;
            if ($urandom_range(0, 3) == 0)
                subj_buf.push_back(pick_blank());
            case (elems[k])
                EL_BLANK:
                    greedy = 1'b0;
                EL_LITERAL:
                begin
                    greedy = 1'b0;
                    subj_buf.push_back(literal_of(k));
                end
                EL_PERCENT:
                begin
                    greedy = 1'b0;
                    subj_buf.push_back(CH_PERCENT);
                end
                EL_CHAR:
                begin
                    greedy = 1'b0;
                    subj_buf.push_back($urandom_range(0, 1) ? pick_literal()
                                                            : 8'($urandom_range(128, 255)));
                end
                EL_BADSPEC:
                begin
                    greedy = 1'b0;
                    subj_buf.push_back(8'($urandom_range(1, 255)));
                end
                EL_STRING:
                    repeat ($urandom_range(1, 5))
                        subj_buf.push_back(8'($urandom_range(33, 255)));
                EL_SIGNED:
                begin
                    if ($urandom_range(0, 2) == 0)
                        subj_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    add_run("0123456789", 1, 4);
                end
                EL_UNSIGNED: add_run("0123456789", 1, 4);
                EL_HEX:      add_run("0123456789abcdefABCDEF", 1, 4);
                EL_OCTAL:    add_run("01234567", 1, 4);
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        subj_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    case ($urandom_range(0, 2))
                        0: add_run("0123456789", 1, 3);
                        1:
                        begin
                            add_run("0123456789", 1, 3);
                            subj_buf.push_back(CH_DOT);
                            add_run("0123456789", 0, 2);
                        end
                        default:
                        begin
                            subj_buf.push_back(CH_DOT);
                            add_run("0123456789", 1, 2);
                        end
                    endcase
                    if (elems[k] == EL_EXPO && $urandom_range(0, 1) == 1)
                    begin
                        subj_buf.push_back(CH_E);
                        add_run("0123456789", 1, 2);
                    end
                end
            endcase
            // Close a greedy run with a blank most of the time
            if (greedy && $urandom_range(0, 7) != 0)
                subj_buf.push_back(CH_SPACE);
        end
    endfunction

    // Damage a subject: replace, drop, insert or append a byte
    function automatic void damage_subject();
        case ($urandom_range(0, 3))
            0:
                if (subj_buf.size() > 0)
                    subj_buf[$urandom_range(0, subj_buf.size() - 1)] =
                        8'($urandom_range(1, 255));
            1:
                if (subj_buf.size() > 0)
                    subj_buf.delete($urandom_range(0, subj_buf.size() - 1));
            2:
                subj_buf.push_back(8'($urandom_range(33, 126)));
            default:
                subj_buf.insert($urandom_range(0, subj_buf.size()), 8'($urandom_range(1, 255)));
        endcase
    endfunction

    // Queue the subject beats, optionally salted with ignored and stray beats
    function automatic void emit_subject(input bit noisy);
        int r;
        foreach (subj_buf[i])
        begin
            r = noisy ? $urandom_range(0, 59) : 99;
            if (r == 0)
                push_beat(OP_SUBJECT, 6'($urandom()), CH_NUL);
            else if (r == 1)
                push_beat(OP_UNUSED, 6'($urandom()), 8'($urandom()));
            else if (r == 2)
                push_beat(OP_LOAD, 6'($urandom()), 8'($urandom()));
            push_beat(OP_SUBJECT, 6'($urandom()), subj_buf[i]);
        end
        push_beat(OP_END, 6'($urandom()), 8'($urandom()));
    endfunction

    function automatic void subject_text(input string s);
        subj_buf.delete();
        for (int i = 0; i < s.len(); i++)
            subj_buf.push_back(s[i]);
        emit_subject(1'b0);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    req_beat_t cur_beat;
    int        req_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid         <= 1'b0;
            req_ch.opcode        <= OP_LOAD;
            req_ch.pattern_index <= '0;
            req_ch.data_byte     <= '0;
            req_gap = 0;
        end
        else
        begin
            // Predict the beat taken at this edge
            if (req_ch.valid && req_ch.ready)
            begin
                predict_beat(cur_beat);
                beats_done++;
            end
            // Offer the next beat, hold off, or idle
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_q.size() == 0)
                    req_ch.valid <= 1'b0;
                else if (request_q[0].wait_drain && verdict_q.size() != 0)
                    req_ch.valid <= 1'b0;
                else if (request_q.size() > CALM_ITEMS && $urandom_range(0, 9) == 0)
                begin
                    req_gap = $urandom_range(0, 13);
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    cur_beat = request_q.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.opcode        <= cur_beat.opcode;
                    req_ch.pattern_index <= cur_beat.index;
                    req_ch.data_byte     <= cur_beat.value;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    int rsp_hold;
    bit long_hold_done;

    task automatic check_result();
        verdict_t want;
        results_seen++;
        if (verdict_q.size() == 0)
        begin
            $error("unexpected result beat: matched=%0d outcome=%0d fail_position=%0d",
                   rsp_ch.matched, rsp_ch.outcome, rsp_ch.fail_position);
            errors++;
            return;
        end
        want = verdict_q.pop_front();
        if (rsp_ch.matched !== want.matched)
        begin
            $error("matched: expected %0d, got %0d", want.matched, rsp_ch.matched);
            errors++;
        end
        if (rsp_ch.outcome !== want.outcome)
        begin
            $error("outcome: expected %0d, got %0d", want.outcome, rsp_ch.outcome);
            errors++;
        end
        if (rsp_ch.fail_position !== want.position)
        begin
            $error("fail_position: expected %0d, got %0d", want.position,
                   rsp_ch.fail_position);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_result();
            // Stall in bursts; once, stall long enough to back up the input
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= 25)
            begin
                long_hold_done = 1'b1;
                rsp_hold = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (request_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
            begin
                rsp_hold = $urandom_range(0, 13);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: stop when no beat moves on either channel for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int sentence;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_LOAD;
        req_ch.pattern_index = '0;
        req_ch.data_byte     = '0;
        rsp_ch.ready         = 1'b0;
        scan_pos   = 0;
        scan_phase = PH_IDLE;
        fail_code  = OC_MATCH;
        fail_pos   = '0;

        // Fill the whole store: blanks, then percent-l on the last two entries,
        // so the walk runs past the end and reads an implicit terminator
        pat_buf.delete();
        for (int i = 0; i < DEPTH - 2; i++)
            pat_buf.push_back((i % 2) ? CH_TAB : CH_SPACE);
        pat_buf.push_back(CH_PERCENT);
        pat_buf.push_back(CH_L);
        load_pattern();
        push_beat(OP_END, 6'h3F, 8'hFF);

        // %s starting on vertical tab matches empty, leaving trailing text
        pattern_text("%s");
        subject_text("\v");
        // Top byte, zero byte and unused opcode are run content or ignored
        push_beat(OP_SUBJECT, 6'h3F, 8'hFF);
        push_beat(OP_SUBJECT, 6'h00, CH_NUL);
        push_beat(OP_UNUSED, 6'h2A, 8'h80);
        push_beat(OP_END, 6'h15, 8'h7F);
        // Float with exponent, then missing values
        pattern_text("%le");
        subject_text("-.5e7");
        subject_text("%");
        subject_text("+9e");

        // Random patterns, several subjects each
        sentence = 0;
        while (stim_count < ITEM_TARGET || end_count < END_TARGET)
        begin
            make_pattern();
            if (sentence == 8)
                drain_next = 1'b1;
            load_pattern();
            repeat ($urandom_range(2, 6))
            begin
                make_subject();
                if ($urandom_range(0, 3) == 0)
                    damage_subject();
                emit_subject(1'b1);
            end
            sentence++;
        end
        beat_total = request_q.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_done < beat_total || verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
